>>> rtl/core/kti_pkg.sv
// Shared constants, types and channel codes of the keyframe track interpolator.
`default_nettype none

package kti_pkg;

    localparam int KEYS     = 16;
    localparam int IDX_W    = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam int CNT_W    = $clog2(KEYS + 1);
    localparam int TIME_W   = 32;
    localparam int VAL_W    = 32;
    localparam int FRAC_W   = 16;
    localparam int WEIGHT_W = FRAC_W + 1;
    localparam int DIV_CNT_W = $clog2(WEIGHT_W);

    localparam logic [CNT_W-1:0]     KEY_LIMIT   = CNT_W'(KEYS);
    localparam logic [WEIGHT_W-1:0]  WEIGHT_HALF = WEIGHT_W'(1 << (FRAC_W - 1));
    localparam logic [WEIGHT_W-1:0]  WEIGHT_ONE  = WEIGHT_W'(1 << FRAC_W);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST    = DIV_CNT_W'(WEIGHT_W - 1);

    localparam logic OP_APPEND  = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    typedef enum logic [1:0] {
        CH_X = 2'd0,
        CH_Y = 2'd1,
        CH_Z = 2'd2
    } chan_t;

    localparam logic [1:0] CHANNELS = 2'd3;

    typedef struct packed {
        logic [TIME_W-1:0] key_time;
        logic [VAL_W-1:0]  x;
        logic [VAL_W-1:0]  y;
        logic [VAL_W-1:0]  z;
    } key_entry_t;

    typedef struct packed {
        logic             valid;
        chan_t            chan;
        logic [VAL_W-1:0] left;
        logic [VAL_W-1:0] right;
    } mac_req_t;

    typedef struct packed {
        logic             valid;
        chan_t            chan;
        logic [VAL_W-1:0] value;
    } mac_rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/kti_key_ram.sv
// Keyframe memory: one write port, one registered read port.
`default_nettype none

module kti_key_ram (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [kti_pkg::IDX_W-1:0] wr_addr,
    input  kti_pkg::key_entry_t           wr_data,
    input  wire logic [kti_pkg::IDX_W-1:0] rd_addr,
    output kti_pkg::key_entry_t           rd_data
);

    kti_pkg::key_entry_t mem [kti_pkg::KEYS];
    kti_pkg::key_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/core/kti_divider.sv
// Restoring divider for the blend weight ld * 2^16 / (ld + rd), one bit a cycle.
`default_nettype none

module kti_divider (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [kti_pkg::TIME_W-1:0]   left_dist,
    input  wire logic [kti_pkg::TIME_W-1:0]   right_dist,
    output logic                              done,
    output logic [kti_pkg::WEIGHT_W-1:0]      weight
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [kti_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [kti_pkg::TIME_W:0]       den_reg, den_next;
    logic [kti_pkg::TIME_W+1:0]     rem_reg, rem_next;
    logic [kti_pkg::WEIGHT_W-1:0]   q_reg, q_next;

    logic [kti_pkg::TIME_W:0]       den_sum;
    logic [kti_pkg::TIME_W+1:0]     trial;
    logic                           fits;

    assign den_sum = {1'b0, left_dist} + {1'b0, right_dist};
    // First step compares without a shift: it yields the integer bit of the weight.
    assign trial   = (cnt_reg == '0) ? rem_reg : {rem_reg[kti_pkg::TIME_W:0], 1'b0};
    assign fits    = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (start)
        begin
            den_next = den_sum;
            cnt_next = '0;
            if (den_sum == '0)
            begin
                q_next    = kti_pkg::WEIGHT_HALF;
                done_next = 1'b1;
            end
            else
            begin
                rem_next  = {2'b00, left_dist};
                q_next    = '0;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next = fits ? (trial - {1'b0, den_reg}) : trial;
            q_next   = {q_reg[kti_pkg::WEIGHT_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == kti_pkg::DIV_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg <= den_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign done   = done_reg;
    assign weight = q_reg;

endmodule

`default_nettype wire

>>> rtl/core/kti_blend_mac.sv
// Three-stage blend unit: left + floor((right - left) * w / 2^16), one channel per cycle.
`default_nettype none

module kti_blend_mac (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  kti_pkg::mac_req_t               req,
    input  wire logic [kti_pkg::WEIGHT_W-1:0] weight,
    output kti_pkg::mac_rsp_t               rsp
);

    logic                        v1_reg, v2_reg, v3_reg;
    kti_pkg::chan_t              c1_reg, c2_reg, c3_reg;
    logic signed [kti_pkg::VAL_W:0]   d1_reg;
    logic [kti_pkg::VAL_W-1:0]   l1_reg, l2_reg, res_reg;
    logic signed [kti_pkg::VAL_W+kti_pkg::WEIGHT_W+1:0] p2_reg;
    logic [kti_pkg::VAL_W+2:0]   sum3;

    // Floor of the scaled product is its upper bits; the result stays between left and right.
    assign sum3 = {{3{l2_reg[kti_pkg::VAL_W-1]}}, l2_reg}
                + p2_reg[kti_pkg::VAL_W+kti_pkg::WEIGHT_W+1:kti_pkg::FRAC_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= req.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c1_reg  <= req.chan;
        d1_reg  <= $signed({req.right[kti_pkg::VAL_W-1], req.right})
                 - $signed({req.left[kti_pkg::VAL_W-1], req.left});
        l1_reg  <= req.left;
        c2_reg  <= c1_reg;
        p2_reg  <= d1_reg * $signed({1'b0, weight});
        l2_reg  <= l1_reg;
        c3_reg  <= c2_reg;
        res_reg <= sum3[kti_pkg::VAL_W-1:0];
    end

    assign rsp.valid = v3_reg;
    assign rsp.chan  = c3_reg;
    assign rsp.value = res_reg;

endmodule

`default_nettype wire

>>> rtl/core/keyframe_track_interpolator_core.sv
// Top level of the keyframe track interpolator: sequencer, track state and output register.
`default_nettype none

// Channel   Handshake            Payload
// in        in_valid/in_ready    operation, key_time, key_value_x/y/z, time_step
// out       out_valid/out_ready  out_x, out_y, out_z, play_time, track_empty
// cfg       cfg_wr_en            cfg_wr_data (loop_enable)
//
// An append that passes the order and room check writes its key to memory at the
// transfer edge. An advance runs a key scan through the single memory read port,
// then the two key reads, the bit-serial weight divider and the three-channel pass
// through the blend unit. An advance on an empty track goes from idle straight to
// the output state and skips the scan, the key reads, the divider and the blend.
// Reset clears the key count, play position, track length and loop_enable; the key
// memory needs no clearing. in_ready is low while an advance is at work; a result
// waiting on out_ready holds only the next advance, not appends.

module keyframe_track_interpolator_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic                         cfg_wr_data,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         operation,
    input  wire logic [kti_pkg::TIME_W-1:0]   key_time,
    input  wire logic signed [kti_pkg::VAL_W-1:0] key_value_x,
    input  wire logic signed [kti_pkg::VAL_W-1:0] key_value_y,
    input  wire logic signed [kti_pkg::VAL_W-1:0] key_value_z,
    input  wire logic [kti_pkg::TIME_W-1:0]   time_step,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [kti_pkg::VAL_W-1:0]  out_x,
    output logic signed [kti_pkg::VAL_W-1:0]  out_y,
    output logic signed [kti_pkg::VAL_W-1:0]  out_z,
    output logic [kti_pkg::TIME_W-1:0]        play_time,
    output logic                              track_empty
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SCAN  = 8'b0000_0010,
        S_RDL   = 8'b0000_0100,
        S_RDR   = 8'b0000_1000,
        S_DIVGO = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_BLEND = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // Track state
    logic [kti_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [kti_pkg::TIME_W-1:0] track_len_reg, track_len_next;
    logic [kti_pkg::TIME_W-1:0] pos_reg, pos_next;
    logic                       loop_reg;

    // Scan state
    logic [kti_pkg::IDX_W-1:0]  scan_idx_reg, scan_idx_next;
    logic                       issue_done_reg, issue_done_next;
    logic                       pend_reg, pend_next;
    logic [kti_pkg::IDX_W-1:0]  pend_idx_reg, pend_idx_next;
    logic [kti_pkg::IDX_W-1:0]  li_reg, li_next, ri_reg, ri_next;
    logic [kti_pkg::TIME_W-1:0] ld_reg, ld_next, rd_reg, rd_next;
    logic                       have_right_reg, have_right_next;
    logic                       empty_reg, empty_next;

    // Blend operands and results
    kti_pkg::key_entry_t        left_reg, left_next, right_reg, right_next;
    logic [kti_pkg::WEIGHT_W-1:0] w_reg, w_next;
    logic [1:0]                 issue_cnt_reg, issue_cnt_next;
    logic [kti_pkg::VAL_W-1:0]  res_x_reg, res_x_next;
    logic [kti_pkg::VAL_W-1:0]  res_y_reg, res_y_next;
    logic [kti_pkg::VAL_W-1:0]  res_z_reg, res_z_next;

    // Output register
    logic                       out_valid_reg, out_valid_next;
    logic [kti_pkg::VAL_W-1:0]  out_x_reg, out_x_next;
    logic [kti_pkg::VAL_W-1:0]  out_y_reg, out_y_next;
    logic [kti_pkg::VAL_W-1:0]  out_z_reg, out_z_next;
    logic [kti_pkg::TIME_W-1:0] play_time_reg, play_time_next;
    logic                       track_empty_reg, track_empty_next;

    logic                       in_fire;
    logic                       app_ok;
    logic [kti_pkg::TIME_W:0]   sum_pos;
    logic [kti_pkg::TIME_W-1:0] pos_adv;
    logic [kti_pkg::CNT_W-1:0]  cnt_m1;
    logic [kti_pkg::IDX_W-1:0]  ram_rd_addr;
    logic                       ram_wr_en;
    kti_pkg::key_entry_t        ram_wr_data, ram_rd_data;
    logic [kti_pkg::TIME_W-1:0] scan_t;
    logic                       div_start, div_done;
    logic [kti_pkg::WEIGHT_W-1:0] div_weight;
    kti_pkg::mac_req_t          mac_req;
    kti_pkg::mac_rsp_t          mac_rsp;
    kti_pkg::chan_t             issue_chan;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;

    // Append only a strictly later key while room remains.
    assign app_ok = (count_reg < kti_pkg::KEY_LIMIT)
                 && ((count_reg == '0) || (key_time > track_len_reg));

    // Position sum keeps its carry, so an overflowing sum counts as past the end.
    assign sum_pos = {1'b0, pos_reg} + {1'b0, time_step};
    assign pos_adv = (sum_pos > {1'b0, track_len_reg})
                   ? (loop_reg ? '0 : track_len_reg)
                   : sum_pos[kti_pkg::TIME_W-1:0];

    assign cnt_m1 = count_reg - 1'b1;

    assign ram_wr_en            = in_fire && (operation == kti_pkg::OP_APPEND) && app_ok;
    assign ram_wr_data.key_time = key_time;
    assign ram_wr_data.x        = key_value_x;
    assign ram_wr_data.y        = key_value_y;
    assign ram_wr_data.z        = key_value_z;

    always_comb
    begin
        case (state_reg)
            S_RDL:   ram_rd_addr = li_reg;
            S_RDR:   ram_rd_addr = ri_reg;
            default: ram_rd_addr = scan_idx_reg;
        endcase
    end

    kti_key_ram u_key_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (count_reg[kti_pkg::IDX_W-1:0]),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign scan_t = ram_rd_data.key_time;

    kti_divider u_divider (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .left_dist  (ld_reg),
        .right_dist (rd_reg),
        .done       (div_done),
        .weight     (div_weight)
    );

    assign issue_chan = kti_pkg::chan_t'(issue_cnt_reg);

    always_comb
    begin
        mac_req.valid = (state_reg == S_BLEND) && (issue_cnt_reg < kti_pkg::CHANNELS);
        mac_req.chan  = issue_chan;
        case (issue_chan)
            kti_pkg::CH_X:
            begin
                mac_req.left  = left_reg.x;
                mac_req.right = right_reg.x;
            end
            kti_pkg::CH_Y:
            begin
                mac_req.left  = left_reg.y;
                mac_req.right = right_reg.y;
            end
            default:
            begin
                mac_req.left  = left_reg.z;
                mac_req.right = right_reg.z;
            end
        endcase
    end

    kti_blend_mac u_blend_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mac_req),
        .weight (w_reg),
        .rsp    (mac_rsp)
    );

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        track_len_next   = track_len_reg;
        pos_next         = pos_reg;
        scan_idx_next    = scan_idx_reg;
        issue_done_next  = issue_done_reg;
        pend_next        = pend_reg;
        pend_idx_next    = pend_idx_reg;
        li_next          = li_reg;
        ri_next          = ri_reg;
        ld_next          = ld_reg;
        rd_next          = rd_reg;
        have_right_next  = have_right_reg;
        empty_next       = empty_reg;
        left_next        = left_reg;
        right_next       = right_reg;
        w_next           = w_reg;
        issue_cnt_next   = issue_cnt_reg;
        res_x_next       = res_x_reg;
        res_y_next       = res_y_reg;
        res_z_next       = res_z_reg;
        out_x_next       = out_x_reg;
        out_y_next       = out_y_reg;
        out_z_next       = out_z_reg;
        play_time_next   = play_time_reg;
        track_empty_next = track_empty_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        div_start        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (operation == kti_pkg::OP_APPEND))
                begin
                    if (app_ok)
                    begin
                        count_next     = count_reg + 1'b1;
                        track_len_next = key_time;
                    end
                end
                else if (in_fire)
                begin
                    // Start the scan with the fallbacks for a missing side.
                    pos_next        = pos_adv;
                    scan_idx_next   = '0;
                    issue_done_next = 1'b0;
                    pend_next       = 1'b0;
                    li_next         = '0;
                    ri_next         = cnt_m1[kti_pkg::IDX_W-1:0];
                    ld_next         = '0;
                    rd_next         = '0;
                    have_right_next = 1'b0;
                    empty_next      = (count_reg == '0);
                    state_next      = (count_reg == '0) ? S_OUT : S_SCAN;
                end
            end

            S_SCAN:
            begin
                // Issue one read a cycle, compare the key read the cycle before.
                if (!issue_done_reg)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = scan_idx_reg;
                    if (scan_idx_reg == cnt_m1[kti_pkg::IDX_W-1:0])
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (pend_reg)
                begin
                    if (scan_t <= pos_reg)
                    begin
                        li_next = pend_idx_reg;
                        ld_next = pos_reg - scan_t;
                    end
                    if ((scan_t >= pos_reg) && !have_right_reg)
                    begin
                        ri_next         = pend_idx_reg;
                        rd_next         = scan_t - pos_reg;
                        have_right_next = 1'b1;
                    end
                end

                if (issue_done_reg && !pend_reg)
                begin
                    state_next = S_RDL;
                end
            end

            S_RDL:
            begin
                state_next = S_RDR;
            end

            S_RDR:
            begin
                left_next  = ram_rd_data;
                state_next = S_DIVGO;
            end

            S_DIVGO:
            begin
                right_next = ram_rd_data;
                div_start  = 1'b1;
                state_next = S_DIV;
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    w_next         = div_weight;
                    issue_cnt_next = '0;
                    state_next     = S_BLEND;
                end
            end

            S_BLEND:
            begin
                if (issue_cnt_reg < kti_pkg::CHANNELS)
                begin
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
                if (mac_rsp.valid)
                begin
                    case (mac_rsp.chan)
                        kti_pkg::CH_X: res_x_next = mac_rsp.value;
                        kti_pkg::CH_Y: res_y_next = mac_rsp.value;
                        default:
                        begin
                            res_z_next = mac_rsp.value;
                            state_next = S_OUT;
                        end
                    endcase
                end
            end

            S_OUT:
            begin
                // Load the output register once the previous result is taken.
                if (!out_valid_reg || out_ready)
                begin
                    out_x_next       = empty_reg ? '0 : res_x_reg;
                    out_y_next       = empty_reg ? '0 : res_y_reg;
                    out_z_next       = empty_reg ? '0 : res_z_reg;
                    play_time_next   = pos_reg;
                    track_empty_next = empty_reg;
                    out_valid_next   = 1'b1;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            track_len_reg  <= '0;
            pos_reg        <= '0;
            loop_reg       <= 1'b0;
            issue_done_reg <= 1'b0;
            pend_reg       <= 1'b0;
            have_right_reg <= 1'b0;
            issue_cnt_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            track_len_reg  <= track_len_next;
            pos_reg        <= pos_next;
            if (cfg_wr_en)
            begin
                loop_reg <= cfg_wr_data;
            end
            issue_done_reg <= issue_done_next;
            pend_reg       <= pend_next;
            have_right_reg <= have_right_next;
            issue_cnt_reg  <= issue_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg    <= scan_idx_next;
        pend_idx_reg    <= pend_idx_next;
        li_reg          <= li_next;
        ri_reg          <= ri_next;
        ld_reg          <= ld_next;
        rd_reg          <= rd_next;
        empty_reg       <= empty_next;
        left_reg        <= left_next;
        right_reg       <= right_next;
        w_reg           <= w_next;
        res_x_reg       <= res_x_next;
        res_y_reg       <= res_y_next;
        res_z_reg       <= res_z_next;
        out_x_reg       <= out_x_next;
        out_y_reg       <= out_y_next;
        out_z_reg       <= out_z_next;
        play_time_reg   <= play_time_next;
        track_empty_reg <= track_empty_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign out_z       = out_z_reg;
    assign play_time   = play_time_reg;
    assign track_empty = track_empty_reg;

    // The play position never runs past the track end.
    a_pos_in_track: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= track_len_reg)
        else $error("play position beyond track length");

    // The key count never exceeds the memory depth.
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= kti_pkg::KEY_LIMIT)
        else $error("key count beyond depth");

    // An accepted advance holds off the input for at least the next cycle.
    a_adv_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (operation == kti_pkg::OP_ADVANCE)) |=> !in_ready)
        else $error("input ready right after an advance");

    // The blend weight never exceeds one.
    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BLEND) |-> (w_reg <= kti_pkg::WEIGHT_ONE))
        else $error("blend weight above one");

    // An empty-track result carries zero channels.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && track_empty) |-> ((out_x == '0) && (out_y == '0) && (out_z == '0)))
        else $error("empty track result not zero");

endmodule

`default_nettype wire
